// File: src/pate_pkg.sv
package pate_pkg;

  localparam int POS_W   = 7;
  localparam int WORD_W  = 32;
  localparam int FOUND_W = 6;
  localparam int FILL_W  = 7;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_LSRCH  = 3'd4,
    OP_BSRCH  = 3'd5,
    OP_REV    = 3'd6,
    OP_BAD    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_POS  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BAD_OP   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_INS_R,
    S_INS_W,
    S_DEL_R,
    S_DEL_W,
    S_RD_W,
    S_LIN_R,
    S_LIN_C,
    S_BIN_R,
    S_BIN_C,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_REV_D,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [WORD_W-1:0]  value;
    logic [POS_W-1:0]   position;
    logic               last;
    logic               pos_ok;
  } cmd_t;

endpackage

// File: src/pate_front.sv
module pate_front #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_op,
  input  logic [31:0]          in_value,
  input  logic [6:0]           in_position,
  input  logic                 in_last,
  output logic                 c_valid,
  input  logic                 c_ready,
  output pate_pkg::cmd_t       c_cmd
);

  localparam int XW = ($clog2(DEPTH + 1) > pate_pkg::POS_W) ?
                      $clog2(DEPTH + 1) : pate_pkg::POS_W;

  pate_pkg::cmd_t q [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     fill;
  pate_pkg::cmd_t cmd_in;
  logic           push;
  logic           pop;

  always_comb begin
    cmd_in.op       = pate_pkg::op_t'(in_op);
    cmd_in.value    = in_value;
    cmd_in.position = in_position;
    cmd_in.last     = in_last;
    cmd_in.pos_ok   = XW'(in_position) < XW'(DEPTH);
  end

  assign in_ready = fill != 2'd2;
  assign c_valid  = fill != 2'd0;
  assign c_cmd    = q[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = c_valid && c_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/pate_back.sv
module pate_back #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 c_valid,
  output logic                 c_ready,
  input  pate_pkg::cmd_t       c_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [5:0]           out_found,
  output logic [31:0]          out_word,
  output logic [6:0]           out_fill
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > pate_pkg::POS_W) ? CW : pate_pkg::POS_W;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata;
  logic [AW-1:0]     ra;
  logic              we;
  logic [AW-1:0]     wa;
  logic [31:0]       wd;

  pate_pkg::state_t  state, state_next;
  pate_pkg::cmd_t    cmd, cmd_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     lo, lo_next;
  logic [CW-1:0]     hx, hx_next;
  logic [31:0]       tmp, tmp_next;
  pate_pkg::status_t rstat, rstat_next;
  logic [CW-1:0]     rfound, rfound_next;
  logic [31:0]       rword, rword_next;
  logic              ovalid, ovalid_next;
  logic [CW:0]       mid_sum;
  logic [CW-1:0]     mid;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;

  assign pos_x   = XW'(cmd.position);
  assign cnt_x   = XW'(cnt);
  assign mid_sum = {1'b0, lo} + {1'b0, hx} - (CW + 1)'(1);
  assign mid     = mid_sum[CW:1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_comb begin
    state_next  = state;
    cmd_next    = cmd;
    cnt_next    = cnt;
    idx_next    = idx;
    lo_next     = lo;
    hx_next     = hx;
    tmp_next    = tmp;
    rstat_next  = rstat;
    rfound_next = rfound;
    rword_next  = rword;
    ovalid_next = ovalid && !out_ready;
    c_ready     = 1'b0;
    ra          = '0;
    we          = 1'b0;
    wa          = '0;
    wd          = cmd.value;
    unique case (state)
      pate_pkg::S_IDLE: begin
        c_ready = 1'b1;
        if (c_valid) begin
          cmd_next    = c_cmd;
          rstat_next  = pate_pkg::ST_OK;
          rfound_next = '0;
          rword_next  = '0;
          state_next  = pate_pkg::S_EXEC;
        end
      end
      pate_pkg::S_EXEC: begin
        state_next = pate_pkg::S_DONE;
        unique case (cmd.op)
          pate_pkg::OP_LOAD: begin
            if (cmd.pos_ok) begin
              we = 1'b1;
              wa = pos_x[AW-1:0];
              if (cmd.last) begin
                cnt_next = CW'(pos_x + XW'(1));
              end
            end else begin
              rstat_next = pate_pkg::ST_BAD_POS;
            end
          end
          pate_pkg::OP_INSERT: begin
            if (pos_x > cnt_x) begin
              rstat_next = pate_pkg::ST_BAD_POS;
            end else if (cnt == CW'(DEPTH)) begin
              rstat_next = pate_pkg::ST_FULL;
            end else begin
              idx_next   = cnt;
              state_next = pate_pkg::S_INS_R;
            end
          end
          pate_pkg::OP_DELETE: begin
            if (pos_x >= cnt_x) begin
              rstat_next = pate_pkg::ST_BAD_POS;
            end else begin
              idx_next   = CW'(pos_x);
              state_next = pate_pkg::S_DEL_R;
            end
          end
          pate_pkg::OP_READ: begin
            if (pos_x >= cnt_x) begin
              rstat_next = pate_pkg::ST_BAD_POS;
            end else begin
              ra         = pos_x[AW-1:0];
              state_next = pate_pkg::S_RD_W;
            end
          end
          pate_pkg::OP_LSRCH: begin
            rstat_next = pate_pkg::ST_NOTFOUND;
            idx_next   = '0;
            state_next = pate_pkg::S_LIN_R;
          end
          pate_pkg::OP_BSRCH: begin
            rstat_next = pate_pkg::ST_NOTFOUND;
            lo_next    = '0;
            hx_next    = cnt;
            state_next = pate_pkg::S_BIN_R;
          end
          pate_pkg::OP_REV: begin
            idx_next   = '0;
            hx_next    = cnt;
            state_next = pate_pkg::S_REV_A;
          end
          pate_pkg::OP_BAD: begin
            rstat_next = pate_pkg::ST_BAD_OP;
          end
        endcase
      end
      pate_pkg::S_INS_R: begin
        if (XW'(idx) > pos_x) begin
          ra         = AW'(idx - CW'(1));
          state_next = pate_pkg::S_INS_W;
        end else begin
          we         = 1'b1;
          wa         = pos_x[AW-1:0];
          cnt_next   = cnt + CW'(1);
          state_next = pate_pkg::S_DONE;
        end
      end
      pate_pkg::S_INS_W: begin
        we         = 1'b1;
        wa         = AW'(idx);
        wd         = rdata;
        idx_next   = idx - CW'(1);
        state_next = pate_pkg::S_INS_R;
      end
      pate_pkg::S_DEL_R: begin
        if ({1'b0, idx} + (CW + 1)'(1) < {1'b0, cnt}) begin
          ra         = AW'(idx + CW'(1));
          state_next = pate_pkg::S_DEL_W;
        end else begin
          cnt_next   = cnt - CW'(1);
          state_next = pate_pkg::S_DONE;
        end
      end
      pate_pkg::S_DEL_W: begin
        we         = 1'b1;
        wa         = AW'(idx);
        wd         = rdata;
        idx_next   = idx + CW'(1);
        state_next = pate_pkg::S_DEL_R;
      end
      pate_pkg::S_RD_W: begin
        rword_next = rdata;
        state_next = pate_pkg::S_DONE;
      end
      pate_pkg::S_LIN_R: begin
        if (idx < cnt) begin
          ra         = AW'(idx);
          state_next = pate_pkg::S_LIN_C;
        end else begin
          state_next = pate_pkg::S_DONE;
        end
      end
      pate_pkg::S_LIN_C: begin
        if (rdata == cmd.value) begin
          rstat_next  = pate_pkg::ST_OK;
          rfound_next = idx;
          state_next  = pate_pkg::S_DONE;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = pate_pkg::S_LIN_R;
        end
      end
      pate_pkg::S_BIN_R: begin
        if (lo < hx) begin
          ra         = AW'(mid);
          idx_next   = mid;
          state_next = pate_pkg::S_BIN_C;
        end else begin
          state_next = pate_pkg::S_DONE;
        end
      end
      pate_pkg::S_BIN_C: begin
        state_next = pate_pkg::S_BIN_R;
        if (rdata == cmd.value) begin
          rstat_next  = pate_pkg::ST_OK;
          rfound_next = idx;
          state_next  = pate_pkg::S_DONE;
        end else if ($signed(rdata) < $signed(cmd.value)) begin
          lo_next = idx + CW'(1);
        end else begin
          hx_next = idx;
        end
      end
      pate_pkg::S_REV_A: begin
        if (hx != '0 && idx < hx - CW'(1)) begin
          ra         = AW'(idx);
          state_next = pate_pkg::S_REV_B;
        end else begin
          state_next = pate_pkg::S_DONE;
        end
      end
      pate_pkg::S_REV_B: begin
        tmp_next   = rdata;
        ra         = AW'(hx - CW'(1));
        state_next = pate_pkg::S_REV_C;
      end
      pate_pkg::S_REV_C: begin
        we         = 1'b1;
        wa         = AW'(idx);
        wd         = rdata;
        state_next = pate_pkg::S_REV_D;
      end
      pate_pkg::S_REV_D: begin
        we         = 1'b1;
        wa         = AW'(hx - CW'(1));
        wd         = tmp;
        idx_next   = idx + CW'(1);
        hx_next    = hx - CW'(1);
        state_next = pate_pkg::S_REV_A;
      end
      pate_pkg::S_DONE: begin
        if (!ovalid || out_ready) begin
          ovalid_next = 1'b1;
          state_next  = pate_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pate_pkg::S_IDLE;
      cnt    <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      ovalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    idx    <= idx_next;
    lo     <= lo_next;
    hx     <= hx_next;
    tmp    <= tmp_next;
    rstat  <= rstat_next;
    rfound <= rfound_next;
    rword  <= rword_next;
    if (state == pate_pkg::S_DONE && (!ovalid || out_ready)) begin
      out_status <= rstat;
      out_found  <= 6'((XW'(rfound)));
      out_word   <= rword;
      out_fill   <= 7'((XW'(cnt)));
    end
  end

  assign out_valid = ovalid;

endmodule

// File: src/positional_array_table_engine_unit.sv
// Channel  Dir  Signals                 Payload
// s_axis   in   s_tvalid/s_tready       s_tdata: operation, value, position; s_tlast: last_load
// m_axis   out  m_tvalid/m_tready       m_tdata: status, found_index, read_word, fill_count
//
// One item at a time through a single-port-write, registered-read table memory.
// Load, read and bad codes do not walk the table; insert, delete and linear search walk
// it entry by entry, binary search probe by probe, and reverse one swapped pair at a time.
// A two-word queue accepts up to two items while an item runs or a result waits.
// Reset clears the fill count and the handshakes; the table is undefined until written.
module positional_array_table_engine_unit #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // operation[2:0], value[34:3], position[41:35], zero
  input  logic        s_tlast,  // last_load
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // status[2:0], found_index[8:3], read_word[40:9], fill_count[47:41]
);

  logic           c_valid;
  logic           c_ready;
  pate_pkg::cmd_t c_cmd;
  logic [2:0]     status;
  logic [5:0]     found;
  logic [31:0]    word;
  logic [6:0]     fill;

  pate_front #(.DEPTH(DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tdata[2:0]),
    .in_value    (s_tdata[34:3]),
    .in_position (s_tdata[41:35]),
    .in_last     (s_tlast),
    .c_valid     (c_valid),
    .c_ready     (c_ready),
    .c_cmd       (c_cmd)
  );

  pate_back #(.DEPTH(DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .c_valid    (c_valid),
    .c_ready    (c_ready),
    .c_cmd      (c_cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (status),
    .out_found  (found),
    .out_word   (word),
    .out_fill   (fill)
  );

  assign m_tdata = {fill, word, found, status};

endmodule

// File: src/pate_checker.sv
module pate_checker #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  localparam logic [7:0] FILL_MAX = (DEPTH > 127) ? 8'd127 : 8'(DEPTH);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= pate_pkg::ST_BAD_OP) else $error("status code out of range");

  a_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != pate_pkg::ST_OK |-> m_tdata[8:3] == 6'd0)
    else $error("index reported without a hit");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {1'b0, m_tdata[47:41]} <= FILL_MAX) else $error("fill count above depth");

endmodule

bind positional_array_table_engine_unit pate_checker #(.DEPTH(DEPTH)) u_pate_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int N_RANDOM = 1950;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    pate_pkg::status_t status;
    logic [5:0]        found_index;
    logic [31:0]       read_word;
    logic [6:0]        fill_count;
  } table_result_t;

  class table_scoreboard;
    logic [31:0]   words [DEPTH];
    int unsigned   count;
    table_result_t pending [$];
    int            mismatches;

    function new();
      count = 0;
      mismatches = 0;
      for (int i = 0; i < DEPTH; i++) words[i] = '0;
    endfunction

    function void note_item(pate_pkg::op_t op, logic [31:0] val, int unsigned pos, logic last);
      table_result_t r;
      int lo;
      int hi;
      int mid;
      int unsigned s;
      int unsigned e;
      logic [31:0] t;
      r = '0;
      r.status = pate_pkg::ST_OK;
      case (op)
        pate_pkg::OP_LOAD: begin
          if (pos >= DEPTH) r.status = pate_pkg::ST_BAD_POS;
          else begin
            words[pos] = val;
            if (last) count = pos + 1;
          end
        end
        pate_pkg::OP_INSERT: begin
          if (pos > count) r.status = pate_pkg::ST_BAD_POS;
          else if (count >= DEPTH) r.status = pate_pkg::ST_FULL;
          else begin
            for (int i = count; i > pos; i--) words[i] = words[i-1];
            words[pos] = val;
            count++;
          end
        end
        pate_pkg::OP_DELETE: begin
          if (pos >= count) r.status = pate_pkg::ST_BAD_POS;
          else begin
            for (int i = pos; i + 1 < count; i++) words[i] = words[i+1];
            count--;
          end
        end
        pate_pkg::OP_READ: begin
          if (pos >= count) r.status = pate_pkg::ST_BAD_POS;
          else r.read_word = words[pos];
        end
        pate_pkg::OP_LSRCH: begin
          r.status = pate_pkg::ST_NOTFOUND;
          for (int i = 0; i < count; i++)
            if (words[i] == val) begin
              r.status = pate_pkg::ST_OK;
              r.found_index = 6'(i);
              break;
            end
        end
        pate_pkg::OP_BSRCH: begin
          lo = 0;
          hi = int'(count) - 1;
          r.status = pate_pkg::ST_NOTFOUND;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (words[mid] == val) begin
              r.status = pate_pkg::ST_OK;
              r.found_index = 6'(mid);
              break;
            end
            if ($signed(words[mid]) < $signed(val)) lo = mid + 1;
            else hi = mid - 1;
          end
        end
        pate_pkg::OP_REV: begin
          s = 0;
          e = count;
          while (e > 0 && s < e - 1) begin
            t = words[s];
            words[s] = words[e-1];
            words[e-1] = t;
            s++;
            e--;
          end
        end
        default: r.status = pate_pkg::ST_BAD_OP;
      endcase
      r.fill_count = 7'(count);
      pending.push_back(r);
    endfunction

    function void check_result(logic [47:0] data);
      table_result_t got;
      table_result_t want;
      got.status = pate_pkg::status_t'(data[2:0]);
      got.found_index = data[8:3];
      got.read_word = data[40:9];
      got.fill_count = data[47:41];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d idx=%0d rd=%h n=%0d got st=%0d idx=%0d rd=%h n=%0d",
                   want.status, want.found_index, want.read_word, want.fill_count,
                   got.status, got.found_index, got.read_word, got.fill_count);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  table_scoreboard board;
  int  cycles;
  int  stall_mode;
  bit  loaded [DEPTH];
  int unsigned live;

  positional_array_table_engine_unit #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (cycles % 7) < 4;
    endcase
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
  end

  always @(posedge clk)
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end

  // shadow of which entries are written, so that no unwritten entry is ever read
  function automatic bit safe_item(pate_pkg::op_t op, int unsigned pos, logic last);
    case (op)
      pate_pkg::OP_LOAD: begin
        if (pos >= DEPTH || !last) return 1;
        for (int i = 0; i < pos; i++) if (!loaded[i]) return 0;
        return 1;
      end
      default: return 1;
    endcase
  endfunction

  function automatic void track_item(pate_pkg::op_t op, int unsigned pos, logic last);
    case (op)
      pate_pkg::OP_LOAD: if (pos < DEPTH) begin
        loaded[pos] = 1;
        if (last) live = pos + 1;
      end
      pate_pkg::OP_INSERT: if (pos <= live && live < DEPTH) begin
        live++;
        loaded[live-1] = 1;
      end
      pate_pkg::OP_DELETE: if (pos < live) live--;
      default: ;
    endcase
  endfunction

  task automatic send_item(pate_pkg::op_t op, logic [31:0] val, logic [6:0] pos, logic last);
    if (!safe_item(op, pos, last)) last = 1'b0;
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, pos, val, op};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(op, val, pos, last);
    track_item(op, pos, last);
  endtask

  task automatic idle_gap();
    s_tvalid <= 1'b0;
    s_tdata <= 48'({$urandom, $urandom});
    s_tlast <= 1'($urandom_range(0, 1));
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned k;
    pate_pkg::op_t op;
    logic [31:0] val;
    logic [6:0] pos;
    k = $urandom_range(0, 99);
    if (k < 15) op = pate_pkg::OP_LOAD;
    else if (k < 35) op = pate_pkg::OP_INSERT;
    else if (k < 48) op = pate_pkg::OP_DELETE;
    else if (k < 62) op = pate_pkg::OP_READ;
    else if (k < 75) op = pate_pkg::OP_LSRCH;
    else if (k < 88) op = pate_pkg::OP_BSRCH;
    else if (k < 96) op = pate_pkg::OP_REV;
    else op = pate_pkg::OP_BAD;
    pos = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, live + 1));
    if ($urandom_range(0, 2) == 0 && live > 0) val = board.words[$urandom_range(0, live - 1)];
    else if ($urandom_range(0, 3) == 0) val = 32'($signed($urandom_range(0, 40)) - 20);
    else val = $urandom;
    send_item(op, val, pos, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int burst;
    board = new();
    cycles = 0;
    stall_mode = 0;
    live = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(pate_pkg::OP_READ, 0, 0, 0);
    send_item(pate_pkg::OP_DELETE, 0, 0, 0);
    send_item(pate_pkg::OP_LSRCH, 0, 0, 0);
    send_item(pate_pkg::OP_BSRCH, 0, 0, 0);
    send_item(pate_pkg::OP_REV, 0, 0, 0);
    send_item(pate_pkg::OP_INSERT, 32'h7fffffff, 1, 0);
    send_item(pate_pkg::OP_INSERT, 32'h80000000, 0, 0);
    send_item(pate_pkg::OP_REV, 0, 0, 0);
    send_item(pate_pkg::OP_LOAD, 5, 7'd64, 1);
    send_item(pate_pkg::OP_LOAD, 5, 7'd127, 1);
    send_item(pate_pkg::OP_INSERT, 32'hffffffff, 0, 0);
    send_item(pate_pkg::OP_INSERT, 9, 1, 0);
    send_item(pate_pkg::OP_READ, 0, 0, 0);
    send_item(pate_pkg::OP_READ, 0, 1, 0);
    send_item(pate_pkg::OP_READ, 0, 7'd127, 0);
    send_item(pate_pkg::OP_BSRCH, 32'h7fffffff, 0, 0);
    send_item(pate_pkg::OP_BSRCH, 32'h80000000, 0, 0);
    send_item(pate_pkg::OP_LSRCH, 9, 0, 0);
    send_item(pate_pkg::OP_LSRCH, 12345, 0, 0);
    send_item(pate_pkg::OP_DELETE, 0, 7'd3, 0);
    send_item(pate_pkg::OP_BAD, 32'hffffffff, 7'h7f, 1);
    for (int i = 0; i < DEPTH; i++)
      send_item(pate_pkg::OP_LOAD, 32'(i * 3 - 90), 7'(i), i == DEPTH - 1);
    send_item(pate_pkg::OP_INSERT, 1, 0, 0);
    send_item(pate_pkg::OP_BSRCH, 32'(-90), 0, 0);
    send_item(pate_pkg::OP_REV, 0, 0, 0);
    send_item(pate_pkg::OP_DELETE, 0, 7'd63, 0);
    drain();

    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) idle_gap();
        burst = $urandom_range(1, 25);
      end
      burst--;
      random_item();
    end
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: filelist.f
src/pate_pkg.sv
src/pate_front.sv
src/pate_back.sv
src/positional_array_table_engine_unit.sv
src/pate_checker.sv
sim/tb.sv
